// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the ring blur rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define RBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// types, constants and the drop color table of the ring blur block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned PIXELS_DEF = 64;

  localparam int unsigned ACT_W     = 7;
  localparam int unsigned MATCH_W   = 10;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IDX_W     = 6;

  localparam logic [ACT_W-1:0]   ACTIVE_RESET = 7'd64;
  localparam logic [MATCH_W-1:0] MATCH_RESET  = 10'd100;
  localparam logic [7:0]         HUE_LEVEL    = 8'd127;

  localparam logic [1:0] HUE_RED   = 2'd0;
  localparam logic [1:0] HUE_GREEN = 2'd1;
  localparam logic [1:0] HUE_GREY  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_PIXELS = 1'b0,
    CFG_DROP_MATCH    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [9:0] drop_roll;
    logic [1:0] drop_hue;
    logic [6:0] add_red;
    logic [6:0] add_green;
    logic [6:0] add_blue;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic             frame_end;
  } out_word_t;

  // per word control handed from the sequencer to the datapath
  typedef struct packed {
    logic pos_zero;
    logic last;
    logic old_wr;
    logic a_old;
    logic a_fill;
    logic b_old;
    logic b_fill;
  } job_ctl_t;

  typedef struct packed {
    job_ctl_t ctl;
    in_word_t word;
  } job_t;

  function automatic pixel_t hue_base(input logic [1:0] hue);
    pixel_t p;
    p = '0;
    case (hue)
      HUE_RED:   p.red = HUE_LEVEL;
      HUE_GREEN: p.green = HUE_LEVEL;
      HUE_GREY: begin
        p.red   = HUE_LEVEL;
        p.green = HUE_LEVEL;
        p.blue  = HUE_LEVEL;
      end
      default:   p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/rbd_mem.sv =====
// ----------------------------------------------------------------------------
// rbd_mem
// pixel memory, one write port and two registered read ports, write-first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbd_mem #(
  parameter int unsigned DEPTH = rbd_pkg::PIXELS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  rbd_pkg::pixel_t  wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output rbd_pkg::pixel_t  rdata_a_o,
  output rbd_pkg::pixel_t  rdata_b_o
);
  import rbd_pkg::*;

  pixel_t mem [DEPTH];
  pixel_t rdata_a_q;
  pixel_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// config registers, ring position sequencer and read address generation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbd_ctrl #(
  parameter int unsigned PIXELS = rbd_pkg::PIXELS_DEF,
  parameter int unsigned ADDR_W = $clog2(PIXELS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rbd_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  rbd_pkg::in_word_t                in_word_i,
  output logic                             in_ready_o,
  input  logic                             take_i,
  output logic                             rd_en_o,
  output logic [ADDR_W-1:0]                rd_addr_a_o,
  output logic [ADDR_W-1:0]                rd_addr_b_o,
  output logic                             job_valid_o,
  output rbd_pkg::job_t                    job_o,
  output logic [ADDR_W-1:0]                job_pos_o,
  output logic [rbd_pkg::MATCH_W-1:0]      drop_match_o
);
  import rbd_pkg::*;

  localparam int unsigned CNT_W = $clog2(PIXELS + 1);
  localparam int unsigned LW    = (CNT_W > ACT_W) ? CNT_W : ACT_W;

  logic [ACT_W-1:0]   active_q;
  logic [MATCH_W-1:0] match_q;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]   hw_q, hw_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               job_valid_q;
  job_t               job_q;
  logic [ADDR_W-1:0]  job_pos_q;

  logic [LW-1:0]     act_w;
  logic [LW-1:0]     n_w;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  cur_w;
  logic [CNT_W-1:0]  p_w;
  logic [CNT_W-1:0]  p1;
  logic [CNT_W-1:0]  left_w;
  logic [CNT_W-1:0]  right_w;
  logic [ADDR_W-1:0] p;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic              last;
  logic              pos_zero;
  logic              accept;
  job_ctl_t          ctl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
      match_q  <= MATCH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_PIXELS: active_q <= cfg_data_i[ACT_W-1:0];
        CFG_DROP_MATCH:    match_q  <= cfg_data_i[MATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // ring size clamped to 1..PIXELS
  always_comb begin
    act_w = LW'(active_q);
    if (act_w == '0) begin
      n_w = LW'(1);
    end else if (act_w > LW'(PIXELS)) begin
      n_w = LW'(PIXELS);
    end else begin
      n_w = act_w;
    end
    n = n_w[CNT_W-1:0];
  end

  always_comb begin
    cur_w    = CNT_W'(pos_q);
    p_w      = (cur_w >= n) ? '0 : cur_w;
    p        = p_w[ADDR_W-1:0];
    p1       = p_w + CNT_W'(1);
    last     = (p1 >= n);
    pos_zero = (p_w == '0);
    left_w   = n - CNT_W'(1);
    right_w  = last ? '0 : p1;
    addr_a   = pos_zero ? left_w[ADDR_W-1:0] : p;
    addr_b   = right_w[ADDR_W-1:0];

    ctl.pos_zero = pos_zero;
    ctl.last     = last;
    ctl.old_wr   = (p_w >= hw_q);
    ctl.a_old    = (CNT_W'(addr_a) < hw_q);
    ctl.a_fill   = (CNT_W'(addr_a) < fill_q);
    ctl.b_old    = (CNT_W'(addr_b) < hw_q);
    ctl.b_fill   = (CNT_W'(addr_b) < fill_q);

    pos_d  = last ? '0 : p1[ADDR_W-1:0];
    hw_d   = last ? '0 : ((p_w >= hw_q) ? p1 : hw_q);
    fill_d = (p_w >= fill_q) ? p1 : fill_q;
  end

  assign in_ready_o = !job_valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hw_q        <= '0;
      fill_q      <= '0;
      job_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q  <= pos_d;
        hw_q   <= hw_d;
        fill_q <= fill_d;
      end
      if (accept) begin
        job_valid_q <= 1'b1;
      end else if (take_i) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.ctl  <= ctl;
      job_q.word <= in_word_i;
      job_pos_q  <= p;
    end
  end

  assign rd_en_o      = accept;
  assign rd_addr_a_o  = addr_a;
  assign rd_addr_b_o  = addr_b;
  assign job_valid_o  = job_valid_q;
  assign job_o        = job_q;
  assign job_pos_o    = job_pos_q;
  assign drop_match_o = match_q;

  `RBD_ASSERT(a_hw_within_fill, clk_i, rst_ni, hw_q <= fill_q, "frame prefix beyond fill count")
  `RBD_ASSERT(a_pos_within_hw, clk_i, rst_ni, CNT_W'(pos_q) <= hw_q, "position ahead of frame prefix")
  `RBD_ASSERT_NEXT(a_job_hold, clk_i, rst_ni, job_valid_q && !take_i, job_valid_q && $stable(job_pos_q) && $stable(job_q), "stalled job changed")

endmodule

// ===== rtl/rbd_dp.sv =====
// ----------------------------------------------------------------------------
// rbd_dp
// neighbor select, 1-2-1 smoothing, drop insert, write-back and output word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbd_dp #(
  parameter int unsigned PIXELS = rbd_pkg::PIXELS_DEF,
  parameter int unsigned ADDR_W = $clog2(PIXELS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  rbd_pkg::job_t                job_i,
  input  logic [ADDR_W-1:0]            job_pos_i,
  input  logic [rbd_pkg::MATCH_W-1:0]  drop_match_i,
  input  rbd_pkg::pixel_t              new_a_i,
  input  rbd_pkg::pixel_t              new_b_i,
  input  rbd_pkg::pixel_t              old_a_i,
  input  rbd_pkg::pixel_t              old_b_i,
  output logic                         take_o,
  output logic                         wr_en_o,
  output logic                         wr_old_en_o,
  output logic [ADDR_W-1:0]            wr_addr_o,
  output rbd_pkg::pixel_t              wr_new_o,
  output rbd_pkg::pixel_t              wr_old_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output rbd_pkg::out_word_t           out_word_o
);
  import rbd_pkg::*;

  function automatic logic [7:0] smooth(input logic [7:0] l, input logic [7:0] c,
                                        input logic [7:0] r);
    logic [9:0] s;
    s = {2'b00, l} + {1'b0, c, 1'b0} + {2'b00, r};
    return s[9:2];
  endfunction

  logic      out_valid_q;
  out_word_t out_word_q;
  pixel_t    win_q;
  pixel_t    z_prev_q;
  pixel_t    z_cur_q;

  pixel_t    pa, pb;
  pixel_t    left, centre, right;
  pixel_t    base;
  pixel_t    res;
  logic      advance;
  logic      drop;
  logic [ADDR_W+IDX_W-1:0] pos_ext;

  always_comb begin
    pa = job_i.ctl.a_old ? old_a_i : (job_i.ctl.a_fill ? new_a_i : '0);
    pb = job_i.ctl.b_old ? old_b_i : (job_i.ctl.b_fill ? new_b_i : '0);
    left   = job_i.ctl.pos_zero ? pa : win_q;
    centre = job_i.ctl.pos_zero ? z_prev_q : pa;
    right  = pb;

    base = hue_base(job_i.word.drop_hue);
    drop = (job_i.word.drop_roll == drop_match_i);
    if (drop) begin
      res.red   = base.red + {1'b0, job_i.word.add_red};
      res.green = base.green + {1'b0, job_i.word.add_green};
      res.blue  = base.blue + {1'b0, job_i.word.add_blue};
    end else begin
      res.red   = smooth(left.red, centre.red, right.red);
      res.green = smooth(left.green, centre.green, right.green);
      res.blue  = smooth(left.blue, centre.blue, right.blue);
    end
    pos_ext = {{IDX_W{1'b0}}, job_pos_i};
  end

  assign take_o      = !out_valid_q || out_ready_i;
  assign advance     = job_valid_i && take_o;
  assign wr_en_o     = advance;
  assign wr_old_en_o = advance && job_i.ctl.old_wr;
  assign wr_addr_o   = job_pos_i;
  assign wr_new_o    = res;
  assign wr_old_o    = centre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      z_prev_q    <= '0;
      z_cur_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && job_i.ctl.pos_zero) begin
        z_cur_q <= res;
      end
      // frame swap: entry zero of the new previous frame
      if (advance && job_i.ctl.last) begin
        z_prev_q <= job_i.ctl.pos_zero ? res : z_cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      win_q                  <= centre;
      out_word_q.pixel_index <= pos_ext[IDX_W-1:0];
      out_word_q.red_out     <= res.red;
      out_word_q.green_out   <= res.green;
      out_word_q.blue_out    <= res.blue;
      out_word_q.frame_end   <= job_i.ctl.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/ring_blur_with_random_drops_top.sv =====
// ----------------------------------------------------------------------------
// ring_blur_with_random_drops_top
// 1-2-1 ring blur over the previous frame with random colored drops
// ----------------------------------------------------------------------------
// an accepted input word is registered as a job along with its memory reads;
//   the output word is registered when the datapath takes the job
// throughput: one word per cycle unless output stalls; a word reads two entries of
//   each pixel memory on its two ports, left neighbor from a window reg past pos 0
// reset: position, frame prefix and fill counts cleared, config set to defaults,
//   at once; no clearing pass, entries past the fill count read as zero
`timescale 1ns / 1ps

module ring_blur_with_random_drops_top #(
  parameter int unsigned PIXELS = rbd_pkg::PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbd_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rbd_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rbd_pkg::out_word_t             out_word_o
);
  import rbd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(PIXELS);

  logic               take;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
  logic               job_valid;
  job_t               job;
  logic [ADDR_W-1:0]  job_pos;
  logic [MATCH_W-1:0] drop_match;
  pixel_t             new_a, new_b, old_a, old_b;
  logic               wr_en, wr_old_en;
  logic [ADDR_W-1:0]  wr_addr;
  pixel_t             wr_new, wr_old;

  rbd_ctrl #(
    .PIXELS (PIXELS),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_word_i    (in_word_i),
    .in_ready_o   (in_ready_o),
    .take_i       (take),
    .rd_en_o      (rd_en),
    .rd_addr_a_o  (rd_addr_a),
    .rd_addr_b_o  (rd_addr_b),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_pos_o    (job_pos),
    .drop_match_o (drop_match)
  );

  // newest value of each entry
  rbd_mem #(
    .DEPTH (PIXELS),
    .AW    (ADDR_W)
  ) u_mem_new (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_new),
    .re_i      (rd_en),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (new_a),
    .rdata_b_o (new_b)
  );

  // previous frame value of entries rewritten in this frame
  rbd_mem #(
    .DEPTH (PIXELS),
    .AW    (ADDR_W)
  ) u_mem_old (
    .clk_i     (clk_i),
    .we_i      (wr_old_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_old),
    .re_i      (rd_en),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (old_a),
    .rdata_b_o (old_b)
  );

  rbd_dp #(
    .PIXELS (PIXELS),
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_pos_i    (job_pos),
    .drop_match_i (drop_match),
    .new_a_i      (new_a),
    .new_b_i      (new_b),
    .old_a_i      (old_a),
    .old_b_i      (old_b),
    .take_o       (take),
    .wr_en_o      (wr_en),
    .wr_old_en_o  (wr_old_en),
    .wr_addr_o    (wr_addr),
    .wr_new_o     (wr_new),
    .wr_old_o     (wr_old),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o)
  );

endmodule
